[sv/flx_pkg.sv]
// Shared constants for the flux extremes tracker.
// Used by every module of the block; depends on nothing.
package flx_pkg;

    localparam int DataWidthDefault = 32;
    localparam int FracBitsDefault  = 16;

    // Threshold reset value in whole units (20.0).
    localparam int ThrResetInt = 20;

    // One record holds the five sample fields.
    localparam int NumFields = 5;
    localparam int F_DENS    = 0;
    localparam int F_U       = 1;
    localparam int F_V       = 2;
    localparam int F_X       = 3;
    localparam int F_Y       = 4;

    // Extreme slots, in output order.
    localparam int NumSlots = 4;
    localparam int SlotW    = 2;
    localparam int CntW     = 3;
    localparam int S_UMAX   = 0;
    localparam int S_UMIN   = 1;
    localparam int S_VMAX   = 2;
    localparam int S_VMIN   = 3;

endpackage

[sv/flx_front.sv]
// Input register and flux multiplier stage of the flux extremes tracker.
// Depends on flx_pkg for the record layout.
module flx_front #(
    parameter int DATA_WIDTH = flx_pkg::DataWidthDefault
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [DATA_WIDTH-1:0]  i_density,
    input  logic [DATA_WIDTH-1:0]  i_vel_u,
    input  logic [DATA_WIDTH-1:0]  i_vel_v,
    input  logic [DATA_WIDTH-1:0]  i_pos_x,
    input  logic [DATA_WIDTH-1:0]  i_pos_y,
    input  logic                   i_end_of_set,
    input  logic [DATA_WIDTH-1:0]  i_x_threshold,
    input  logic                   i_drain_idle,
    output logic                   o_take,
    output logic                   o_end,
    output logic                   o_gt,
    output logic signed [2*DATA_WIDTH-1:0] o_uflux,
    output logic signed [2*DATA_WIDTH-1:0] o_vflux,
    output logic [flx_pkg::NumFields-1:0][DATA_WIDTH-1:0] o_samp
);

    logic r_v1, n_v1, r_v2, n_v2;
    logic [flx_pkg::NumFields-1:0][DATA_WIDTH-1:0] r_s1, r_s2;
    logic r_end1, r_end2, r_gt2;
    logic signed [2*DATA_WIDTH-1:0] r_pu, r_pv, n_pu, n_pv;
    logic n_gt, s1_move, accept_in;

    assign o_take     = r_v2 && (!r_end2 || i_drain_idle);
    assign s1_move    = r_v1 && (!r_v2 || o_take);
    assign o_in_stall = r_v1 && !s1_move;
    assign accept_in  = i_in_valid && !o_in_stall;

    always_comb begin
        n_v1 = accept_in ? 1'b1 : (s1_move ? 1'b0 : r_v1);
        n_v2 = s1_move ? 1'b1 : (o_take ? 1'b0 : r_v2);
        n_pu = $signed(r_s1[flx_pkg::F_DENS]) * $signed(r_s1[flx_pkg::F_U]);
        n_pv = $signed(r_s1[flx_pkg::F_DENS]) * $signed(r_s1[flx_pkg::F_V]);
        n_gt = $signed(r_s1[flx_pkg::F_X]) > $signed(i_x_threshold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
        if (accept_in) begin
            r_s1[flx_pkg::F_DENS] <= i_density;
            r_s1[flx_pkg::F_U]    <= i_vel_u;
            r_s1[flx_pkg::F_V]    <= i_vel_v;
            r_s1[flx_pkg::F_X]    <= i_pos_x;
            r_s1[flx_pkg::F_Y]    <= i_pos_y;
            r_end1                <= i_end_of_set;
        end
        if (s1_move) begin
            r_s2   <= r_s1;
            r_end2 <= r_end1;
            r_gt2  <= n_gt;
            r_pu   <= n_pu;
            r_pv   <= n_pv;
        end
    end

    assign o_end   = r_end2;
    assign o_gt    = r_gt2;
    assign o_uflux = r_pu;
    assign o_vflux = r_pv;
    assign o_samp  = r_s2;

endmodule

[sv/flx_track.sv]
// Running extremes and their sample records for the flux extremes tracker.
// Depends on flx_pkg for the record layout and slot codes.
module flx_track #(
    parameter int DATA_WIDTH = flx_pkg::DataWidthDefault
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_take,
    input  logic                   i_end,
    input  logic                   i_gt,
    input  logic signed [2*DATA_WIDTH-1:0] i_uflux,
    input  logic signed [2*DATA_WIDTH-1:0] i_vflux,
    input  logic [flx_pkg::NumFields-1:0][DATA_WIDTH-1:0] i_samp,
    output logic                   o_load,
    output logic [flx_pkg::NumSlots-1:0][flx_pkg::NumFields-1:0][DATA_WIDTH-1:0] o_rec
);

    logic r_seeded;
    logic signed [2*DATA_WIDTH-1:0] r_umax, r_umin, r_vmax, r_vmin;
    logic signed [2*DATA_WIDTH-1:0] n_umax, n_umin, n_vmax, n_vmin;
    logic [flx_pkg::NumSlots-1:0][flx_pkg::NumFields-1:0][DATA_WIDTH-1:0] r_rec, n_rec;

    always_comb begin
        n_rec  = r_rec;
        n_umax = r_umax;
        n_vmax = r_vmax;
        // The first sample of a set seeds both minima before any compare.
        n_umin = r_seeded ? r_umin : i_uflux;
        n_vmin = r_seeded ? r_vmin : i_vflux;
        if (i_gt) begin
            if (i_uflux > r_umax) begin
                n_umax = i_uflux;
                n_rec[flx_pkg::S_UMAX] = i_samp;
            end else if (i_uflux < n_umin) begin
                n_umin = i_uflux;
                n_rec[flx_pkg::S_UMIN] = i_samp;
            end
            if (i_vflux > r_vmax) begin
                n_vmax = i_vflux;
                n_rec[flx_pkg::S_VMAX] = i_samp;
            end else if (i_vflux < n_vmin) begin
                n_vmin = i_vflux;
                n_rec[flx_pkg::S_VMIN] = i_samp;
            end
        end
    end

    assign o_load = i_take && i_end;
    assign o_rec  = n_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_load) begin
            r_seeded <= 1'b0;
            r_umax   <= '0;
            r_umin   <= '0;
            r_vmax   <= '0;
            r_vmin   <= '0;
            r_rec    <= '0;
        end else if (i_take) begin
            r_seeded <= 1'b1;
            r_umax   <= n_umax;
            r_umin   <= n_umin;
            r_vmax   <= n_vmax;
            r_vmin   <= n_vmin;
            r_rec    <= n_rec;
        end
    end

endmodule

[sv/flx_drain.sv]
// Output buffer that delivers the four extreme records of a set in slot order.
// Depends on flx_pkg for the slot count and record layout.
module flx_drain #(
    parameter int DATA_WIDTH = flx_pkg::DataWidthDefault
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [flx_pkg::NumSlots-1:0][flx_pkg::NumFields-1:0][DATA_WIDTH-1:0] i_rec,
    output logic                   o_idle,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [flx_pkg::SlotW-1:0] o_slot,
    output logic [flx_pkg::NumFields-1:0][DATA_WIDTH-1:0] o_head,
    output logic                   o_last
);

    logic [flx_pkg::NumSlots-1:0][flx_pkg::NumFields-1:0][DATA_WIDTH-1:0] r_buf;
    logic [flx_pkg::CntW-1:0] r_cnt;
    logic out_acc;

    assign o_idle      = (r_cnt == '0);
    assign o_out_valid = !o_idle;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_slot      = flx_pkg::SlotW'(flx_pkg::NumSlots - int'(r_cnt));
    assign o_last      = (r_cnt == flx_pkg::CntW'(1));
    assign o_head      = r_buf[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= flx_pkg::CntW'(flx_pkg::NumSlots);
        end else if (out_acc) begin
            r_cnt <= r_cnt - flx_pkg::CntW'(1);
        end
        if (i_load) begin
            r_buf <= i_rec;
        end else if (out_acc) begin
            // Records move toward the head; the tail entry is a don't-care.
            for (int i = 0; i < flx_pkg::NumSlots - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

endmodule

[sv/flux_extremes_tracker.sv]
// The four records of a set are loaded into the output buffer register as the end sample
// is taken and presented from there one record per cycle while the receiver does not stall.
// Throughput: one sample per cycle; an end sample waits in the product stage while the
// previous set's records drain, which takes longer if the receiver stalls.
// Reset (synchronous, active low) clears all extremes and records to zero and sets
// the x threshold to 20.0 in the configured fixed-point format.
module flux_extremes_tracker #(
    parameter int DATA_WIDTH = flx_pkg::DataWidthDefault,
    parameter int FRAC_BITS  = flx_pkg::FracBitsDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [DATA_WIDTH-1:0] i_density,
    input  logic [DATA_WIDTH-1:0] i_vel_u,
    input  logic [DATA_WIDTH-1:0] i_vel_v,
    input  logic [DATA_WIDTH-1:0] i_pos_x,
    input  logic [DATA_WIDTH-1:0] i_pos_y,
    input  logic                  i_end_of_set,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [flx_pkg::SlotW-1:0] o_slot,
    output logic [DATA_WIDTH-1:0] o_out_density,
    output logic [DATA_WIDTH-1:0] o_out_u,
    output logic [DATA_WIDTH-1:0] o_out_v,
    output logic [DATA_WIDTH-1:0] o_out_x,
    output logic [DATA_WIDTH-1:0] o_out_y,
    output logic                  o_last,
    input  logic                  i_cfg_we,
    input  logic [DATA_WIDTH-1:0] i_cfg_data
);

    localparam logic [DATA_WIDTH-1:0] ThrReset =
        DATA_WIDTH'(64'(flx_pkg::ThrResetInt) << FRAC_BITS);

    logic [DATA_WIDTH-1:0] r_x_threshold;
    logic drain_idle, take, end2, gt2, load;
    logic signed [2*DATA_WIDTH-1:0] uflux, vflux;
    logic [flx_pkg::NumFields-1:0][DATA_WIDTH-1:0] samp, head;
    logic [flx_pkg::NumSlots-1:0][flx_pkg::NumFields-1:0][DATA_WIDTH-1:0] rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_threshold <= ThrReset;
        end else if (i_cfg_we) begin
            r_x_threshold <= i_cfg_data;
        end
    end

    flx_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_density    (i_density),
        .i_vel_u      (i_vel_u),
        .i_vel_v      (i_vel_v),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_end_of_set (i_end_of_set),
        .i_x_threshold(r_x_threshold),
        .i_drain_idle (drain_idle),
        .o_take       (take),
        .o_end        (end2),
        .o_gt         (gt2),
        .o_uflux      (uflux),
        .o_vflux      (vflux),
        .o_samp       (samp)
    );

    flx_track #(.DATA_WIDTH(DATA_WIDTH)) u_track (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_end  (end2),
        .i_gt   (gt2),
        .i_uflux(uflux),
        .i_vflux(vflux),
        .i_samp (samp),
        .o_load (load),
        .o_rec  (rec)
    );

    flx_drain #(.DATA_WIDTH(DATA_WIDTH)) u_drain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_rec      (rec),
        .o_idle     (drain_idle),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_slot     (o_slot),
        .o_head     (head),
        .o_last     (o_last)
    );

    assign o_out_density = head[flx_pkg::F_DENS];
    assign o_out_u       = head[flx_pkg::F_U];
    assign o_out_v       = head[flx_pkg::F_V];
    assign o_out_x       = head[flx_pkg::F_X];
    assign o_out_y       = head[flx_pkg::F_Y];

    // A new set of records is only loaded into an empty output buffer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) load |-> drain_idle)
        else $error("records loaded while previous set still draining");

    // Records leave in slot order, one slot further per transaction.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=>
            (o_out_valid && o_slot == $past(o_slot) + flx_pkg::SlotW'(1)))
        else $error("output slot sequence broken");

    // After the fourth record is taken, the output is not valid in the following cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |=> !o_out_valid)
        else $error("output valid after final record");

endmodule
